### hw/rtl/bwarr_pkg.sv
package bwarr_pkg;

    // Input beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        logic [15:0] instr_word;
        logic [31:0] instr_pc;
        logic [31:0] fault_address;
        logic        fault_write;
    } rb_in_t;

    // Result beat
    typedef struct packed {
        logic [2:0]  out_index;
        logic [31:0] out_value;
        logic [31:0] restored_pc;
        logic        waiting;
        logic        last;
    } rb_out_t;

    // Operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_ASSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam int unsigned NUM_AREGS = 8;
    localparam int unsigned AREG_W    = $clog2(NUM_AREGS);

    // Opcode masks and patterns
    localparam logic [15:0] MASK_XOP      = 16'hb1f8;
    localparam logic [15:0] PAT_BCD       = 16'h8108;
    localparam logic [15:0] PAT_ADDX_B    = 16'h9108;
    localparam logic [15:0] PAT_ADDX_W    = 16'h9148;
    localparam logic [15:0] PAT_ADDX_L    = 16'h9188;
    localparam logic [15:0] MASK_CMPM     = 16'hf138;
    localparam logic [15:0] PAT_CMPM      = 16'hb108;
    localparam logic [15:0] MASK_MOVEM    = 16'hfb80;
    localparam logic [15:0] PAT_MOVEM     = 16'h4880;
    localparam logic [15:0] PAT_TAS       = 16'h4ac0;
    localparam logic [15:0] PAT_SCC       = 16'h50c0;
    localparam logic [15:0] MASK_CHK      = 16'hf1c0;
    localparam logic [15:0] PAT_CHK       = 16'h4180;
    localparam logic [15:0] MASK_BITDYN   = 16'hf100;
    localparam logic [15:0] PAT_BITDYN    = 16'h0100;
    localparam logic [15:0] MASK_BITSTAT  = 16'hff00;
    localparam logic [15:0] PAT_BITSTAT   = 16'h0800;
    localparam logic [15:0] MASK_TAS      = 16'hffc0;
    localparam logic [15:0] MASK_SCC      = 16'hf0c0;
    localparam logic [15:0] MASK_ADDA     = 16'hb0c0;
    localparam logic [15:0] PAT_ADDA      = 16'h90c0;
    localparam logic [15:0] PAT_CMPA      = 16'hb0c0;

    // Addressing mode field codes
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;

    // One rollback plan: up to one source and one destination adjustment
    typedef struct packed {
        logic        src_en;
        logic        src_sub;
        logic [2:0]  src_idx;
        logic [2:0]  src_sz;
        logic        dst_en;
        logic        dst_sub;
        logic        dst_cond;
        logic [2:0]  dst_idx;
        logic [2:0]  dst_sz;
    } rb_plan_t;

    function automatic logic [2:0] move_size(input logic [1:0] code);
        logic [2:0] sz;
        begin
            case (code)
                2'd1:    sz = 3'd1;
                2'd2:    sz = 3'd4;
                2'd3:    sz = 3'd2;
                default: sz = 3'd0;
            endcase
            return sz;
        end
    endfunction

    function automatic logic [2:0] gen_size(input logic [1:0] code);
        logic [2:0] sz;
        begin
            case (code)
                2'd0:    sz = 3'd1;
                2'd2:    sz = 3'd4;
                default: sz = 3'd2;
            endcase
            return sz;
        end
    endfunction

    // Operand size for the generic (An)+ / -(An) case
    function automatic logic [2:0] generic_size(input logic [15:0] op);
        logic [2:0] sz;
        begin
            if ((op & MASK_MOVEM) == PAT_MOVEM)
                sz = 3'd0;
            else if ((op & MASK_BITDYN) == PAT_BITDYN || (op & MASK_BITSTAT) == PAT_BITSTAT ||
                     (op & MASK_TAS) == PAT_TAS || (op & MASK_SCC) == PAT_SCC)
                sz = 3'd1;
            else if ((op & MASK_CHK) == PAT_CHK)
                sz = 3'd2;
            else if ((op & MASK_ADDA) == PAT_ADDA || (op & MASK_SCC) == PAT_CMPA)
                sz = op[8] ? 3'd4 : 3'd2;
            else
                sz = gen_size(op[7:6]);
            return sz;
        end
    endfunction

    // Decode the held opcode into a rollback plan
    function automatic rb_plan_t rb_decode(input logic [15:0] op, input logic wr);
        rb_plan_t   p;
        logic [2:0] gs;
        logic [15:0] xop;
        begin
            p         = '0;
            p.src_idx = op[2:0];
            p.dst_idx = op[11:9];
            gs        = gen_size(op[7:6]);
            xop       = op & MASK_XOP;
            if (op >= 16'h1000 && op < 16'h4000) begin
                p.src_sz  = move_size(op[13:12]);
                p.dst_sz  = p.src_sz;
                p.src_en  = (op[5:3] == MODE_POSTINC) || (op[5:3] == MODE_PREDEC);
                p.src_sub = (op[5:3] == MODE_POSTINC);
                p.dst_en  = wr && ((op[8:6] == MODE_POSTINC) || (op[8:6] == MODE_PREDEC));
                p.dst_sub = (op[8:6] == MODE_POSTINC);
            end else if (xop == PAT_BCD) begin
                p.src_en   = 1'b1;
                p.src_sz   = 3'd1;
                p.dst_en   = 1'b1;
                p.dst_cond = 1'b1;
                p.dst_sz   = 3'd1;
            end else if (xop inside {PAT_ADDX_B, PAT_ADDX_W, PAT_ADDX_L}) begin
                p.src_en   = 1'b1;
                p.src_sz   = gs;
                p.dst_en   = 1'b1;
                p.dst_cond = 1'b1;
                p.dst_sz   = gs;
            end else if ((op & MASK_CMPM) == PAT_CMPM) begin
                p.src_en   = 1'b1;
                p.src_sub  = 1'b1;
                p.src_sz   = gs;
                p.dst_en   = 1'b1;
                p.dst_sub  = 1'b1;
                p.dst_cond = 1'b1;
                p.dst_sz   = gs;
            end else if (op[5:3] == MODE_POSTINC || op[5:3] == MODE_PREDEC) begin
                p.src_en  = 1'b1;
                p.src_sub = op[3];
                p.src_sz  = generic_size(op);
            end
            return p;
        end
    endfunction

endpackage

### hw/rtl/bus_wait_address_register_rollback_unit.sv
// Write beat: updates one live register; the unit stays idle, so the next beat is not held.
// Bus wait assert: copy, then source step, then destination step on the shared adder.
// Bus wait clear: accept, then 8 result beats, one per cycle through the output register
// when the sink does not stall; the next input beat is taken after the last.
// Reset clears the live registers, wait flag, saved PC and sequencer; the saved copy
// is not reset and needs no clearing pass.
module bus_wait_address_register_rollback_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  bwarr_pkg::rb_in_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output bwarr_pkg::rb_out_t  result
);
    import bwarr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SRC  = 4'b0010,
        S_DST  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         live_reg  [NUM_AREGS];
    logic [31:0]         saved_reg [NUM_AREGS];
    logic                wait_reg, wait_next;
    logic [31:0]         pc_reg;
    logic [AREG_W-1:0]   cnt_reg, cnt_next;
    rb_plan_t            plan_reg;
    logic [31:0]         fault_reg;
    logic                out_valid_reg, out_valid_next;
    rb_out_t             out_reg;

    logic                accept;
    logic                do_write, do_assert, do_clear;
    logic                out_load;
    logic [AREG_W-1:0]   rd_idx;
    logic [31:0]         rd_data;
    logic                alu_sub;
    logic [2:0]          alu_sz;
    logic [31:0]         alu_sum;
    logic                alu_hit;
    logic                sv_wr;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign do_write     = accept && (item.operation == OP_WRITE);
    assign do_assert    = accept && (item.operation == OP_ASSERT) && !wait_reg;
    assign do_clear     = accept && (item.operation == OP_CLEAR) && wait_reg;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Shared read port on the saved copy
    always_comb
    begin
        case (state_reg)
            S_SRC:   rd_idx = plan_reg.src_idx;
            S_DST:   rd_idx = plan_reg.dst_idx;
            default: rd_idx = cnt_reg;
        endcase
    end
    assign rd_data = saved_reg[rd_idx];

    // Shared adjust unit: add/subtract a small size, compare with fault address
    assign alu_sub = (state_reg == S_DST) ? plan_reg.dst_sub : plan_reg.src_sub;
    assign alu_sz  = (state_reg == S_DST) ? plan_reg.dst_sz : plan_reg.src_sz;
    assign alu_sum = alu_sub ? (rd_data - {29'd0, alu_sz}) : (rd_data + {29'd0, alu_sz});
    assign alu_hit = (fault_reg == rd_data);

    always_comb
    begin
        sv_wr = 1'b0;
        if (state_reg == S_SRC)
            sv_wr = plan_reg.src_en;
        else if (state_reg == S_DST)
            sv_wr = plan_reg.dst_en && (!plan_reg.dst_cond || alu_hit);
    end

    // Result register load
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !result_stall);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (do_assert)
                begin
                    wait_next  = 1'b1;
                    state_next = S_SRC;
                end
                else if (do_clear)
                begin
                    wait_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_SRC:
                state_next = S_DST;
            S_DST:
                state_next = S_IDLE;
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == AREG_W'(NUM_AREGS - 1))
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (do_assert)
                pc_reg <= item.instr_pc;
        end
    end

    // Live register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AREGS; i++)
                live_reg[i] <= '0;
        end
        else if (do_write)
            live_reg[item.reg_index] <= item.reg_value;
        else if (do_clear)
        begin
            for (int i = 0; i < NUM_AREGS; i++)
                live_reg[i] <= saved_reg[i];
        end
    end

    // Saved copy: snapshot on assert, one adjust per step
    always_ff @(posedge clk)
    begin
        if (do_assert)
        begin
            for (int i = 0; i < NUM_AREGS; i++)
                saved_reg[i] <= live_reg[i];
        end
        else if (sv_wr)
            saved_reg[rd_idx] <= alu_sum;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (do_assert)
        begin
            plan_reg  <= rb_decode(item.instr_word, item.fault_write);
            fault_reg <= item.fault_address;
        end
        if (out_load)
        begin
            out_reg.out_index   <= cnt_reg;
            out_reg.out_value   <= rd_data;
            out_reg.restored_pc <= pc_reg;
            out_reg.waiting     <= 1'b0;
            out_reg.last        <= (cnt_reg == AREG_W'(NUM_AREGS - 1));
        end
    end

endmodule
